/* rtl/egcd_pkg.sv */
// Shared widths, controller states and command/status types for the extended GCD core.
package egcd_pkg;

   localparam int OPER_W        = 31;
   localparam int COEF_W        = 32;
   localparam int WIDTH_DEFAULT = 32;
   localparam int DIV_STEPS     = OPER_W;
   localparam int STEP_W        = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W    = ((2 * OPER_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((OPER_W + 2 * COEF_W + 7) / 8) * 8;

   typedef logic [OPER_W-1:0]        oper_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic cur_zero;
   } status_type;

endpackage

/* rtl/egcd_dpath.sv */
// Datapath: remainder and coefficient registers, bit-serial divider with shift-add products.
module egcd_dpath (
   input  logic               clock,
   input  egcd_pkg::cmd_type  cmd,
   input  egcd_pkg::oper_type left_value,
   input  egcd_pkg::oper_type right_value,
   output egcd_pkg::status_type status,
   output egcd_pkg::oper_type divisor,
   output egcd_pkg::coef_type coeff_left,
   output egcd_pkg::coef_type coeff_right
);
   import egcd_pkg::*;

   oper_type prev_r_ff, prev_r_in, cur_r_ff, cur_r_in;
   coef_type prev_s_ff, prev_s_in, cur_s_ff, cur_s_in;
   coef_type prev_t_ff, prev_t_in, cur_t_ff, cur_t_in;
   oper_type rem_ff, rem_in, dvd_ff, dvd_in;
   coef_type acc_s_ff, acc_s_in, acc_t_ff, acc_t_in;
   oper_type out_g_ff, out_g_in;
   coef_type out_x_ff, out_x_in, out_y_ff, out_y_in;

   logic [OPER_W:0]   shifted;
   logic [OPER_W+1:0] diff;
   logic              qbit;

   // One restoring division step: bring down the next dividend bit and try to subtract.
   assign shifted = {rem_ff, dvd_ff[OPER_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, cur_r_ff};
   assign qbit    = ~diff[OPER_W+1];

   always_comb begin
      prev_r_in = prev_r_ff;
      cur_r_in  = cur_r_ff;
      prev_s_in = prev_s_ff;
      cur_s_in  = cur_s_ff;
      prev_t_in = prev_t_ff;
      cur_t_in  = cur_t_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      acc_s_in  = acc_s_ff;
      acc_t_in  = acc_t_ff;
      out_g_in  = out_g_ff;
      out_x_in  = out_x_ff;
      out_y_in  = out_y_ff;
      if (cmd.load) begin
         prev_r_in = left_value;
         cur_r_in  = right_value;
         prev_s_in = COEF_W'(1);
         cur_s_in  = '0;
         prev_t_in = '0;
         cur_t_in  = COEF_W'(1);
      end
      if (cmd.div_init) begin
         rem_in   = '0;
         dvd_in   = prev_r_ff;
         acc_s_in = '0;
         acc_t_in = '0;
      end
      if (cmd.div_step) begin
         rem_in   = qbit ? diff[OPER_W-1:0] : shifted[OPER_W-1:0];
         dvd_in   = {dvd_ff[OPER_W-2:0], 1'b0};
         // The quotient arrives MSB first, so q*cur accumulates as a shift-add.
         acc_s_in = (acc_s_ff <<< 1) + (qbit ? cur_s_ff : '0);
         acc_t_in = (acc_t_ff <<< 1) + (qbit ? cur_t_ff : '0);
      end
      if (cmd.commit) begin
         prev_r_in = cur_r_ff;
         cur_r_in  = rem_ff;
         prev_s_in = cur_s_ff;
         cur_s_in  = prev_s_ff - acc_s_ff;
         prev_t_in = cur_t_ff;
         cur_t_in  = prev_t_ff - acc_t_ff;
      end
      if (cmd.emit) begin
         out_g_in = prev_r_ff;
         out_x_in = prev_s_ff;
         out_y_in = prev_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      prev_r_ff <= prev_r_in;
      cur_r_ff  <= cur_r_in;
      prev_s_ff <= prev_s_in;
      cur_s_ff  <= cur_s_in;
      prev_t_ff <= prev_t_in;
      cur_t_ff  <= cur_t_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      acc_s_ff  <= acc_s_in;
      acc_t_ff  <= acc_t_in;
      out_g_ff  <= out_g_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
   end

   assign status.cur_zero = (cur_r_ff == '0);
   assign divisor         = out_g_ff;
   assign coeff_left      = out_x_ff;
   assign coeff_right     = out_y_ff;

endmodule

/* rtl/egcd_ctrl.sv */
// Controller: sequences Euclid rounds and serial division steps, owns the handshakes.
module egcd_ctrl #(
   parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  egcd_pkg::status_type status,
   output egcd_pkg::cmd_type    cmd
);
   import egcd_pkg::*;

   localparam int ROUND_MAX = 2 * WIDTH;
   localparam int RND_W     = $clog2(ROUND_MAX + 1);
   localparam logic [RND_W-1:0]  ROUND_LIMIT = RND_W'(ROUND_MAX);
   localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(DIV_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RND_W-1:0]  round_ff, round_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      round_in   = round_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.cur_zero || round_ff == ROUND_LIMIT) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            round_in   = round_ff + RND_W'(1);
            state_in   = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_divide_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> ($past(state_ff) == ST_CHECK || $past(state_ff) == ST_DIVIDE))
      else $error("divide state entered from an unexpected state");

   a_full_division: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(step_ff) == LAST_STEP))
      else $error("round committed before all quotient bits were produced");

   a_round_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (round_ff < ROUND_LIMIT))
      else $error("division started past the round limit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

endmodule

/* rtl/extended_gcd_core.sv */
// Top level of the extended GCD core: stream ports, controller and datapath.
//
// Each request beat carries two non-negative 31-bit operands a and b; the core
// answers with one response beat holding g = gcd(a, b) and Bezout coefficients
// x and y (32-bit two's complement) such that a*x + b*y = g. When b is zero the
// answer is g = a, x = 1, y = 0. The core works on one item at a time: a request
// is taken only while the controller is idle, but a finished result sits in an
// output register, so the next request can be accepted while the previous
// response still waits for rsp_tready. Each Euclid round is one check, 31 steps
// of the one-bit-per-cycle restoring divider and one update; an item needs at
// most 46 rounds for 31-bit operands. The rounds are capped at 2*WIDTH. The
// quotient times coefficient products are formed by shift-add inside the
// divider steps, so the core has no multiplier.
module extended_gcd_core #(
   parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: left_value[30:0], right_value[61:31], zero pad.
   input  logic [egcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: divisor[30:0], coeff_left[62:31], coeff_right[94:63], zero pad.
   output logic [egcd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import egcd_pkg::*;

   cmd_type    cmd;
   status_type status;
   oper_type   left_value, right_value, divisor;
   coef_type   coeff_left, coeff_right;

   assign left_value  = req_tdata[OPER_W-1:0];
   assign right_value = req_tdata[2*OPER_W-1:OPER_W];

   egcd_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   egcd_dpath u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .left_value  (left_value),
      .right_value (right_value),
      .status      (status),
      .divisor     (divisor),
      .coeff_left  (coeff_left),
      .coeff_right (coeff_right)
   );

   assign rsp_tdata = {(RSP_DATA_W - OPER_W - 2 * COEF_W)'(0),
                       coeff_right, coeff_left, divisor};

   // An accepted beat always moves the controller into the check state.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item was in progress");

endmodule
